[rtl/core/smrc_pkg.sv]
// Package for the sample mean and range calibrator.
// Holds widths, reset constants, kind codes and the sequencer state type.
// Depends on nothing.
package smrc_pkg;

  // Field and state widths.
  localparam int SAMPLE_BITS = 10;
  localparam int COUNT_BITS  = 16;
  localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
  localparam int STEP_BITS   = $clog2(SUM_BITS);

  // Samples per run after reset.
  localparam logic [COUNT_BITS-1:0] DEFAULT_COUNT = COUNT_BITS'(100);

  // Measurement kinds; the fourth code marks a run that gives no result.
  localparam logic [1:0] KIND_LOW    = 2'd0;
  localparam logic [1:0] KIND_CENTRE = 2'd1;
  localparam logic [1:0] KIND_HIGH   = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  // Sequencer states, one-hot.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DIV  = 2'b10
  } state_t;

endpackage

[rtl/core/sample_mean_and_range_calibrator_top.sv]
// Top level of the sample mean and range calibrator.
// Accumulates sum, minimum and maximum per run and divides with a shared
// restoring divider. Depends on smrc_pkg.

// Each request carries one ADC sample and a measurement kind; the kind given
// with the first sample of a run is kept for the whole run. A sample that does
// not end a run is folded into the run and busy stays low. The sample that ends
// a run (the configured count reached or passed) starts the mean division:
// the single shared subtract and compare unit produces one quotient bit per
// cycle, so busy stays high until all SUM_BITS (26) quotient bits are done;
// out_valid then shows the result on out_ for exactly one cycle as busy falls.
// The receiver cannot stall; a result must be captured in that cycle. A run
// latched with kind code three is gathered and cleared but gives no result.
// Writing cfg_wr_data with cfg_wr_en sets the samples per run (0 stores 1);
// write it only while the block is idle.
module sample_mean_and_range_calibrator_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [smrc_pkg::SAMPLE_BITS-1:0] in_sample_value,
  input  logic [1:0]                       in_measure_kind,
  output logic                             out_valid,
  output logic [1:0]                       out_result_kind,
  output logic [smrc_pkg::SAMPLE_BITS-1:0] out_mean_value,
  output logic [smrc_pkg::SAMPLE_BITS-1:0] out_dead_band,
  input  logic                             cfg_wr_en,
  input  logic [smrc_pkg::COUNT_BITS-1:0]  cfg_wr_data
);
  import smrc_pkg::*;

  // Configuration and run state.
  state_t                state_r, state_nxt;
  logic [COUNT_BITS-1:0] sample_count_r, sample_count_nxt;
  logic [COUNT_BITS-1:0] samples_seen_r, samples_seen_nxt;
  logic [SUM_BITS-1:0]   running_sum_r, running_sum_nxt;
  logic [SAMPLE_BITS-1:0] running_min_r, running_min_nxt;
  logic [SAMPLE_BITS-1:0] running_max_r, running_max_nxt;
  logic [1:0]            run_kind_r, run_kind_nxt;

  // Divider and finished-run registers.
  logic [SUM_BITS-1:0]    quo_r, quo_nxt;
  logic [COUNT_BITS-1:0]  rem_r, rem_nxt;
  logic [COUNT_BITS-1:0]  divisor_r, divisor_nxt;
  logic [STEP_BITS-1:0]   step_r, step_nxt;
  logic [SAMPLE_BITS-1:0] band_r, band_nxt;
  logic [1:0]             kind_r, kind_nxt;

  // Result registers.
  logic                   out_valid_r, out_valid_nxt;
  logic [1:0]             out_kind_r, out_kind_nxt;
  logic [SAMPLE_BITS-1:0] out_mean_r, out_mean_nxt;
  logic [SAMPLE_BITS-1:0] out_band_r, out_band_nxt;

  // Per-sample datapath.
  logic                   accept;
  logic [1:0]             kind_eff;
  logic [SAMPLE_BITS-1:0] min_new, max_new;
  logic [SUM_BITS-1:0]    sum_new;
  logic [COUNT_BITS:0]    taken;
  logic                   last;

  // Shared divider step.
  logic [COUNT_BITS:0]    shifted;
  logic [COUNT_BITS:0]    trial;
  logic                   qbit;

  assign busy   = (state_r == ST_DIV);
  assign accept = start && !busy;

  // Fold the incoming sample into the running figures.
  always_comb begin
    kind_eff = (samples_seen_r == '0) ? in_measure_kind : run_kind_r;
    min_new  = (in_sample_value < running_min_r) ? in_sample_value : running_min_r;
    max_new  = (in_sample_value > running_max_r) ? in_sample_value : running_max_r;
    sum_new  = running_sum_r + SUM_BITS'(in_sample_value);
    taken    = {1'b0, samples_seen_r} + (COUNT_BITS+1)'(1);
    last     = (taken >= {1'b0, sample_count_r});
  end

  // One restoring division step: bring down a dividend bit, try a subtract.
  always_comb begin
    shifted = {rem_r, quo_r[SUM_BITS-1]};
    trial   = shifted - {1'b0, divisor_r};
    qbit    = !trial[COUNT_BITS];
  end

  // Sequencer and next-state logic.
  always_comb begin
    state_nxt        = state_r;
    sample_count_nxt = sample_count_r;
    samples_seen_nxt = samples_seen_r;
    running_sum_nxt  = running_sum_r;
    running_min_nxt  = running_min_r;
    running_max_nxt  = running_max_r;
    run_kind_nxt     = run_kind_r;
    quo_nxt          = quo_r;
    rem_nxt          = rem_r;
    divisor_nxt      = divisor_r;
    step_nxt         = step_r;
    band_nxt         = band_r;
    kind_nxt         = kind_r;
    out_valid_nxt    = 1'b0;
    out_kind_nxt     = out_kind_r;
    out_mean_nxt     = out_mean_r;
    out_band_nxt     = out_band_r;

    if (cfg_wr_en) begin
      sample_count_nxt = (cfg_wr_data == '0) ? COUNT_BITS'(1) : cfg_wr_data;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (last) begin
            // Run complete: hand the totals to the divider and clear the run.
            quo_nxt          = sum_new;
            rem_nxt          = '0;
            divisor_nxt      = taken[COUNT_BITS-1:0];
            step_nxt         = '0;
            band_nxt         = max_new - min_new;
            kind_nxt         = kind_eff;
            samples_seen_nxt = '0;
            running_sum_nxt  = '0;
            running_min_nxt  = '1;
            running_max_nxt  = '0;
            run_kind_nxt     = KIND_LOW;
            state_nxt        = ST_DIV;
          end else begin
            samples_seen_nxt = taken[COUNT_BITS-1:0];
            running_sum_nxt  = sum_new;
            running_min_nxt  = min_new;
            running_max_nxt  = max_new;
            run_kind_nxt     = kind_eff;
          end
        end
      end
      ST_DIV: begin
        quo_nxt  = {quo_r[SUM_BITS-2:0], qbit};
        rem_nxt  = qbit ? trial[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
        step_nxt = step_r + STEP_BITS'(1);
        if (step_r == STEP_BITS'(SUM_BITS-1)) begin
          // Last quotient bit: publish the result for one cycle.
          out_valid_nxt = (kind_r != KIND_NONE);
          out_kind_nxt  = kind_r;
          out_mean_nxt  = quo_nxt[SAMPLE_BITS-1:0];
          out_band_nxt  = band_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and run state, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      sample_count_r <= DEFAULT_COUNT;
      samples_seen_r <= '0;
      running_sum_r  <= '0;
      running_min_r  <= '1;
      running_max_r  <= '0;
      run_kind_r     <= KIND_LOW;
      step_r         <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      sample_count_r <= sample_count_nxt;
      samples_seen_r <= samples_seen_nxt;
      running_sum_r  <= running_sum_nxt;
      running_min_r  <= running_min_nxt;
      running_max_r  <= running_max_nxt;
      run_kind_r     <= run_kind_nxt;
      step_r         <= step_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    divisor_r  <= divisor_nxt;
    band_r     <= band_nxt;
    kind_r     <= kind_nxt;
    out_kind_r <= out_kind_nxt;
    out_mean_r <= out_mean_nxt;
    out_band_r <= out_band_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_mean_value  = out_mean_r;
  assign out_dead_band   = out_band_r;

`ifndef SYNTHESIS
  // A result only follows the final division step.
  a_valid_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_DIV))
    else $error("result strobe without a preceding division");

  // The samples-per-run register never holds zero.
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    sample_count_r != '0)
    else $error("sample count register is zero");

  // The step counter stays inside the dividend while dividing.
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (step_r < STEP_BITS'(SUM_BITS)))
    else $error("divider step counter out of range");

  // A run-ending request starts the divider and clears the run.
  a_last_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last) |=> (busy && samples_seen_r == '0 && running_sum_r == '0))
    else $error("run end did not start division or clear the run");
`endif

endmodule

[tb/testbench.sv]
// Testbench for the sample mean and range calibrator top level.
// Drives sample requests and count writes, predicts results or takes them from
// the directed table, and checks each strobed result. Depends on smrc_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
  import smrc_pkg::*;

  // A quiet stretch longer than this means the block has stopped answering.
  localparam int WATCHDOG_LIMIT = 4000;
  // Cycles to let an unseen division (kind three run) finish before a write.
  localparam int DRAIN_CYCLES   = SUM_BITS + 8;
  localparam int NUM_ROWS       = 32;
  localparam int NUM_SEGMENTS   = 16;
  localparam int SEGMENT_ITEMS  = 52;

  typedef struct packed {
    logic [1:0]             kind;
    logic [SAMPLE_BITS-1:0] mean;
    logic [SAMPLE_BITS-1:0] band;
  } run_result_t;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_op_t;
  typedef enum logic [1:0] {CHK_MODEL, CHK_RESULT, CHK_NONE} row_check_t;

  typedef struct packed {
    row_op_t                op;
    logic [COUNT_BITS-1:0]  value;
    logic [1:0]             kind;
    row_check_t             chk;
    logic [1:0]             want_kind;
    logic [SAMPLE_BITS-1:0] want_mean;
    logic [SAMPLE_BITS-1:0] want_band;
  } plan_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic [SAMPLE_BITS-1:0] in_sample_value;
  logic [1:0]             in_measure_kind;
  logic                   out_valid;
  logic [1:0]             out_result_kind;
  logic [SAMPLE_BITS-1:0] out_mean_value;
  logic [SAMPLE_BITS-1:0] out_dead_band;
  logic                   cfg_wr_en;
  logic [COUNT_BITS-1:0]  cfg_wr_data;

  // Predictor state: the run being gathered and the samples per run.
  logic [COUNT_BITS-1:0]  acc_seen;
  logic [SUM_BITS-1:0]    acc_sum;
  logic [SAMPLE_BITS-1:0] acc_min;
  logic [SAMPLE_BITS-1:0] acc_max;
  logic [1:0]             acc_kind;
  logic [COUNT_BITS-1:0]  run_length;

  run_result_t pending_runs [$];
  run_result_t oldest_run;
  run_result_t new_run;
  bit          run_done;
  int          mismatches;
  int          quiet_cycles;

  // Expectation typed into the stimulus table for the current request.
  bit          typed_on;
  bit          typed_has;
  run_result_t typed_res;

  // Directed stimulus. Rows checked by the predictor carry no expectation.
  plan_row_t plan [0:NUM_ROWS-1] = '{
    // Two samples at the reset count of 100 give nothing yet.
    '{ROW_SAMPLE, 16'd10,    KIND_HIGH,   CHK_NONE,   KIND_LOW,    10'd0,    10'd0},
    '{ROW_SAMPLE, 16'd30,    KIND_LOW,    CHK_NONE,   KIND_LOW,    10'd0,    10'd0},
    // Count lowered to one mid-run: the next sample closes a three-sample run.
    '{ROW_CFG,    16'd1,     KIND_LOW,    CHK_MODEL,  KIND_LOW,    10'd0,    10'd0},
    '{ROW_SAMPLE, 16'd50,    KIND_LOW,    CHK_RESULT, KIND_HIGH,   10'd30,   10'd40},
    '{ROW_SAMPLE, 16'd0,     KIND_LOW,    CHK_RESULT, KIND_LOW,    10'd0,    10'd0},
    '{ROW_SAMPLE, 16'd1023,  KIND_HIGH,   CHK_RESULT, KIND_HIGH,   10'd1023, 10'd0},
    '{ROW_SAMPLE, 16'd512,   KIND_CENTRE, CHK_RESULT, KIND_CENTRE, 10'd512,  10'd0},
    '{ROW_SAMPLE, 16'd5,     KIND_NONE,   CHK_NONE,   KIND_LOW,    10'd0,    10'd0},
    '{ROW_SAMPLE, 16'h155,   KIND_CENTRE, CHK_MODEL,  KIND_LOW,    10'd0,    10'd0},
    '{ROW_SAMPLE, 16'h2aa,   KIND_HIGH,   CHK_MODEL,  KIND_LOW,    10'd0,    10'd0},
    // A zero count stores one.
    '{ROW_CFG,    16'd0,     KIND_LOW,    CHK_MODEL,  KIND_LOW,    10'd0,    10'd0},
    '{ROW_SAMPLE, 16'd7,     KIND_LOW,    CHK_RESULT, KIND_LOW,    10'd7,    10'd0},
    // Pairs: full-scale dead band, and a kind that is ignored after the first.
    '{ROW_CFG,    16'd2,     KIND_LOW,    CHK_MODEL,  KIND_LOW,    10'd0,    10'd0},
    '{ROW_SAMPLE, 16'd0,     KIND_HIGH,   CHK_MODEL,  KIND_LOW,    10'd0,    10'd0},
    '{ROW_SAMPLE, 16'd1023,  KIND_LOW,    CHK_RESULT, KIND_HIGH,   10'd511,  10'd1023},
    '{ROW_SAMPLE, 16'd1023,  KIND_CENTRE, CHK_MODEL,  KIND_LOW,    10'd0,    10'd0},
    '{ROW_SAMPLE, 16'd1023,  KIND_NONE,   CHK_RESULT, KIND_CENTRE, 10'd1023, 10'd0},
    // A run latched with kind three is gathered but gives no result.
    '{ROW_CFG,    16'd3,     KIND_LOW,    CHK_MODEL,  KIND_LOW,    10'd0,    10'd0},
    '{ROW_SAMPLE, 16'd9,     KIND_NONE,   CHK_MODEL,  KIND_LOW,    10'd0,    10'd0},
    '{ROW_SAMPLE, 16'd10,    KIND_LOW,    CHK_MODEL,  KIND_LOW,    10'd0,    10'd0},
    '{ROW_SAMPLE, 16'd20,    KIND_CENTRE, CHK_NONE,   KIND_LOW,    10'd0,    10'd0},
    // Count lowered below the samples already taken: mean divides by four.
    '{ROW_CFG,    16'd5,     KIND_LOW,    CHK_MODEL,  KIND_LOW,    10'd0,    10'd0},
    '{ROW_SAMPLE, 16'd100,   KIND_CENTRE, CHK_MODEL,  KIND_LOW,    10'd0,    10'd0},
    '{ROW_SAMPLE, 16'd200,   KIND_HIGH,   CHK_MODEL,  KIND_LOW,    10'd0,    10'd0},
    '{ROW_SAMPLE, 16'd300,   KIND_LOW,    CHK_MODEL,  KIND_LOW,    10'd0,    10'd0},
    '{ROW_CFG,    16'd2,     KIND_LOW,    CHK_MODEL,  KIND_LOW,    10'd0,    10'd0},
    '{ROW_SAMPLE, 16'd400,   KIND_LOW,    CHK_RESULT, KIND_CENTRE, 10'd250,  10'd300},
    // Largest count, then cut short.
    '{ROW_CFG,    16'd65535, KIND_LOW,    CHK_MODEL,  KIND_LOW,    10'd0,    10'd0},
    '{ROW_SAMPLE, 16'd1023,  KIND_LOW,    CHK_MODEL,  KIND_LOW,    10'd0,    10'd0},
    '{ROW_SAMPLE, 16'd0,     KIND_HIGH,   CHK_MODEL,  KIND_LOW,    10'd0,    10'd0},
    '{ROW_CFG,    16'd1,     KIND_LOW,    CHK_MODEL,  KIND_LOW,    10'd0,    10'd0},
    '{ROW_SAMPLE, 16'd3,     KIND_CENTRE, CHK_RESULT, KIND_LOW,    10'd342,  10'd1023}
  };

  // Sender idle percentage per random phase. The receiver cannot hold results
  // off; the first and third phases run at full rate.
  int idle_by_phase [0:3] = '{0, 68, 0, 24};

  sample_mean_and_range_calibrator_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_sample_value (in_sample_value),
    .in_measure_kind (in_measure_kind),
    .out_valid       (out_valid),
    .out_result_kind (out_result_kind),
    .out_mean_value  (out_mean_value),
    .out_dead_band   (out_dead_band),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Start a fresh run in the predictor.
  task automatic clear_run();
    acc_seen = '0;
    acc_sum  = '0;
    acc_min  = '1;
    acc_max  = '0;
    acc_kind = KIND_LOW;
  endtask

  // Fold one accepted sample into the predicted run; report a finished run.
  task automatic absorb_sample(input logic [SAMPLE_BITS-1:0] v, input logic [1:0] k,
                               output bit done, output run_result_t res);
    logic [COUNT_BITS:0] taken;
    done = 1'b0;
    res  = '0;
    if (acc_seen == '0) acc_kind = k;
    if (v < acc_min) acc_min = v;
    if (v > acc_max) acc_max = v;
    acc_sum = acc_sum + SUM_BITS'(v);
    taken   = {1'b0, acc_seen} + (COUNT_BITS+1)'(1);
    if (taken < {1'b0, run_length}) begin
      acc_seen = taken[COUNT_BITS-1:0];
    end else begin
      res.kind = acc_kind;
      res.mean = SAMPLE_BITS'(acc_sum / SUM_BITS'(taken));
      res.band = acc_max - acc_min;
      done     = (acc_kind != KIND_NONE);
      clear_run();
    end
  endtask

  // Check strobed results against the oldest expectation, then predict the
  // request accepted at this edge and track count writes.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_run();
      run_length = DEFAULT_COUNT;
    end else begin
      if (out_valid) begin
        if (pending_runs.size() == 0) begin
          $error("result with no expected result: kind %0d mean %0d band %0d",
                 out_result_kind, out_mean_value, out_dead_band);
          mismatches++;
        end else begin
          oldest_run = pending_runs.pop_front();
          if (out_result_kind !== oldest_run.kind) begin
            $error("result_kind: expected %0d, got %0d", oldest_run.kind, out_result_kind);
            mismatches++;
          end
          if (out_mean_value !== oldest_run.mean) begin
            $error("mean_value: expected %0d, got %0d", oldest_run.mean, out_mean_value);
            mismatches++;
          end
          if (out_dead_band !== oldest_run.band) begin
            $error("dead_band: expected %0d, got %0d", oldest_run.band, out_dead_band);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        absorb_sample(in_sample_value, in_measure_kind, run_done, new_run);
        if (typed_on) begin
          run_done = typed_has;
          new_run  = typed_res;
        end
        if (run_done) pending_runs.push_back(new_run);
      end
      if (cfg_wr_en) run_length = (cfg_wr_data == '0) ? COUNT_BITS'(1) : cfg_wr_data;
    end
  end

  // Watchdog on cycles with no accepted request, result or count write.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request, idling first at the given rate; returns at a falling
  // edge after the request was taken. Idle cycles carry noise on the fields.
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] v, input logic [1:0] k,
                             input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start           <= 1'b0;
      in_sample_value <= SAMPLE_BITS'($urandom);
      in_measure_kind <= 2'($urandom);
      @(negedge clk);
    end
    start           <= 1'b1;
    in_sample_value <= v;
    in_measure_kind <= k;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Hold requests off until every expected result has come and any silent
  // division has had time to finish.
  task automatic wait_quiet();
    start <= 1'b0;
    while (pending_runs.size() != 0 || busy) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  // Write the samples-per-run register while the block is idle.
  task automatic write_count(input logic [COUNT_BITS-1:0] value);
    wait_quiet();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    int style;
    int center;
    int level;
    logic [SAMPLE_BITS-1:0] v;
    logic [1:0] k;

    rst_n           = 1'b0;
    start           = 1'b0;
    in_sample_value = '0;
    in_measure_kind = KIND_LOW;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    typed_on        = 1'b0;
    typed_has       = 1'b0;
    typed_res       = '0;
    mismatches      = 0;
    quiet_cycles    = 0;
    clear_run();
    run_length = DEFAULT_COUNT;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table.
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (plan[i].op == ROW_CFG) begin
        write_count(plan[i].value);
      end else begin
        typed_on  = (plan[i].chk != CHK_MODEL);
        typed_has = (plan[i].chk == CHK_RESULT);
        typed_res = '{plan[i].want_kind, plan[i].want_mean, plan[i].want_band};
        send_sample(plan[i].value[SAMPLE_BITS-1:0], plan[i].kind, 30);
      end
    end
    typed_on = 1'b0;

    // Random segments. Each one sets a new count, mostly short runs, and the
    // segments do not line up with runs, so counts also change mid-run.
    for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
      if (seg == 0) write_count(COUNT_BITS'(1));
      else if (seg == 1) write_count('0);
      else begin
        level = $urandom_range(0, 9);
        if (level < 6) write_count(COUNT_BITS'($urandom_range(1, 6)));
        else if (level < 9) write_count(COUNT_BITS'($urandom_range(7, 24)));
        else write_count(COUNT_BITS'($urandom));
      end
      style  = $urandom_range(0, 2);
      center = $urandom_range(0, 1023);
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        if (style == 0) begin
          v = SAMPLE_BITS'($urandom);
        end else if (style == 1) begin
          level = center + $urandom_range(0, 14) - 7;
          if (level < 0) level = 0;
          if (level > 1023) level = 1023;
          v = SAMPLE_BITS'(level);
        end else begin
          level = $urandom_range(0, 2);
          v = (level == 0) ? '0 : (level == 1) ? '1 : SAMPLE_BITS'($urandom);
        end
        k = ($urandom_range(0, 9) == 0) ? KIND_NONE : 2'($urandom_range(0, 2));
        send_sample(v, k, idle_by_phase[seg % 4]);
        // Now and then the sender waits for all results to drain.
        if ($urandom_range(0, 39) == 0) wait_quiet();
      end
    end

    wait_quiet();
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
